### rtl/core/bounded_set_table_core_assert.svh
// Assertion macros shared by the bounded set table RTL.
// Expects clk and rst in scope at the point of use.
`ifndef BOUNDED_SET_TABLE_CORE_ASSERT_SVH
`define BOUNDED_SET_TABLE_CORE_ASSERT_SVH

// Same-cycle property, held off while in reset.
`define BST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define BST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/bst_pkg.sv
// Bounded set table: shared constants, operation codes and interface structs.
// No dependencies.
package bst_pkg;

  localparam int CAPACITY  = 64;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 2;
  localparam int OUT_CNT_W = 7;
  localparam int AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // One write port and one read port per cycle.
  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
  } mem_req_t;

  typedef struct packed {
    logic             ok;
    logic             full;
    logic [CNT_W-1:0] count;
  } result_t;

  // Count reported on the port, masked to the port width.
  function automatic logic [OUT_CNT_W-1:0] to_out_count(input logic [CNT_W-1:0] c);
    logic [CNT_W+OUT_CNT_W-1:0] wide;
    wide = {{OUT_CNT_W{1'b0}}, c};
    return wide[OUT_CNT_W-1:0];
  endfunction

endpackage

### rtl/core/bst_store.sv
// Value store of the bounded set table: CAPACITY x DATA_W synchronous RAM.
// One write and one registered read per cycle. Depends on bst_pkg.
module bst_store (
  input  logic                           clk,
  input  bst_pkg::mem_req_t              req,
  output logic [bst_pkg::DATA_W-1:0]     rdata
);
  import bst_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

### rtl/core/bst_seq.sv
// Bounded set table sequencer: entry count, pipelined scan and compacting shift.
// Drives the store through bst_pkg::mem_req_t. Depends on bst_pkg and the assert header.
`include "bounded_set_table_core_assert.svh"

module bst_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bst_pkg::OP_W-1:0]      operation,
  input  logic signed [bst_pkg::DATA_W-1:0] element_value,
  output logic                          res_valid,
  input  logic                          res_take,
  output bst_pkg::result_t              result,
  output bst_pkg::mem_req_t             mem_req,
  input  logic [bst_pkg::DATA_W-1:0]    mem_rdata
);
  import bst_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [OP_W-1:0]   op, op_next;
  logic [DATA_W-1:0] value, value_next;
  logic [CNT_W-1:0]  idx, idx_next;     // next address to read
  logic              pend, pend_next;   // a read is in flight
  logic [AW-1:0]     pidx, pidx_next;   // address of the read in flight
  logic              ok, ok_next;
  logic              full, full_next;

  logic match;
  logic more;

  assign match = pend && (mem_rdata == value);
  assign more  = idx < count;

  always_comb begin
    state_next    = state;
    count_next    = count;
    op_next       = op;
    value_next    = value;
    idx_next      = idx;
    pend_next     = pend;
    pidx_next     = pidx;
    ok_next       = ok;
    full_next     = full;
    mem_req.we    = 1'b0;
    mem_req.waddr = '0;
    mem_req.wdata = value;
    mem_req.raddr = idx[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next    = operation;
          value_next = element_value;
          idx_next   = '0;
          pend_next  = 1'b0;
          ok_next    = 1'b0;
          full_next  = 1'b0;
          if (operation == OP_ADD || operation == OP_REMOVE || operation == OP_SEARCH) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end

      S_SCAN: begin
        if (match) begin
          case (op)
            OP_ADD: begin
              state_next = S_DONE;
            end
            OP_REMOVE: begin
              // compact: entries above the hit move down one place
              ok_next    = 1'b1;
              idx_next   = CNT_W'(pidx) + CNT_W'(1);
              pend_next  = 1'b0;
              state_next = S_SHIFT;
            end
            default: begin
              ok_next    = 1'b1;
              state_next = S_DONE;
            end
          endcase
        end else if (more) begin
          pend_next = 1'b1;
          pidx_next = idx[AW-1:0];
          idx_next  = idx + CNT_W'(1);
        end else begin
          // value absent
          if (op == OP_ADD) begin
            if (count < CNT_W'(CAPACITY)) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = count[AW-1:0];
              count_next    = count + CNT_W'(1);
              ok_next       = 1'b1;
            end else begin
              full_next = 1'b1;
            end
          end
          state_next = S_DONE;
        end
      end

      S_SHIFT: begin
        if (pend) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pidx - AW'(1);
          mem_req.wdata = mem_rdata;
        end
        if (more) begin
          pend_next = 1'b1;
          pidx_next = idx[AW-1:0];
          idx_next  = idx + CNT_W'(1);
        end else begin
          pend_next  = 1'b0;
          count_next = count - CNT_W'(1);
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op    <= op_next;
    value <= value_next;
    idx   <= idx_next;
    pidx  <= pidx_next;
    ok    <= ok_next;
    full  <= full_next;
  end

  assign in_ready     = (state == S_IDLE);
  assign res_valid    = (state == S_DONE);
  assign result.ok    = ok;
  assign result.full  = full;
  assign result.count = count;

  `BST_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY), "entry count above capacity")
  `BST_ASSERT(a_write_phase, mem_req.we |-> (state == S_SCAN || state == S_SHIFT), "store write outside scan or shift")
  `BST_ASSERT(a_shift_addr, (state == S_SHIFT && mem_req.we) |-> (CNT_W'(mem_req.waddr) + CNT_W'(1) < count), "shift writes past the last live entry")
  `BST_ASSERT_NEXT(a_remove_count, state == S_SHIFT && !more, count + CNT_W'(1) == $past(count), "remove did not drop the count by one")

endmodule

### rtl/core/bounded_set_table_core.sv
// Bounded set table: a set of up to CAPACITY (64) distinct 32-bit values held
// unordered in one single-port-read RAM. Each input transfer adds, removes or
// searches one value (any other operation code does nothing) and gives exactly
// one result transfer. An add or search scans the live entries, one entry read
// per cycle through the RAM read port, then passes through the done and idle
// states. A remove that hits at position p scans up to p, shifts the entries
// above p down one place and then passes through the same done and idle states.
// The single RAM read port bounds both the scan and the shift.
// One item is worked at a time; a finished result sits in the output register
// so the next item can be taken while the downstream side stalls.
// Depends on bst_pkg, bst_store and bst_seq.
module bounded_set_table_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bst_pkg::OP_W-1:0]          operation,
  input  logic signed [bst_pkg::DATA_W-1:0] element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              success,
  output logic                              full_rejected,
  output logic [bst_pkg::OUT_CNT_W-1:0]     member_count,
  output logic                              set_empty
);
  import bst_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_take;
  result_t           result;

  bst_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  bst_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .element_value (element_value),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .result        (result),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata)
  );

  // output register: loads whenever it is empty or being drained
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      success       <= result.ok;
      full_rejected <= result.full;
      member_count  <= to_out_count(result.count);
      set_empty     <= (result.count == '0);
    end
  end

endmodule
